@@ sv/sars_pkg.sv @@
// ----------------------------------------------------------------------------
// sars_pkg
// shared widths, defaults and bit-count helpers for the round-robin scheduler
// ----------------------------------------------------------------------------
package sars_pkg;

    localparam int MASK_W              = 32;
    localparam int PRODUCER_W          = 5;
    localparam int ID_W                = 2;
    localparam int ID_COUNT            = 4;
    localparam int COUNT_W             = 6;
    localparam int PRODUCERS_DEF       = 32;
    localparam int CONNECTOR_INDEX_DEF = 31;

    // population count: eight nibble counts, then a short sum
    function automatic logic [COUNT_W-1:0] popcount32(input logic [MASK_W-1:0] v);
        logic [2:0]         nib [8];
        logic [COUNT_W-1:0] sum;
        for (int n = 0; n < 8; n++)
        begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        sum = '0;
        for (int n = 0; n < 8; n++)
        begin
            sum = sum + COUNT_W'(nib[n]);
        end
        return sum;
    endfunction

    // index of the lowest set bit, zero when none
    function automatic logic [PRODUCER_W-1:0] lowest_index(input logic [MASK_W-1:0] v);
        logic [PRODUCER_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = PRODUCER_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ sv/sars_in_if.sv @@
// ----------------------------------------------------------------------------
// sars_in_if
// request channel: connected and wanting producer masks per opportunity
// ----------------------------------------------------------------------------
interface sars_in_if;
    import sars_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] connected_mask;
    logic [MASK_W-1:0] wants_mask;

    modport source (output valid, output connected_mask, output wants_mask, input ready);
    modport sink   (input valid, input connected_mask, input wants_mask, output ready);
endinterface

@@ sv/sars_out_if.sv @@
// ----------------------------------------------------------------------------
// sars_out_if
// grant channel: granted producer, dummy flag and consumed packet id
// ----------------------------------------------------------------------------
interface sars_out_if;
    import sars_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PRODUCER_W-1:0] producer;
    logic                  is_dummy;
    logic [ID_W-1:0]       packet_id;

    modport source (output valid, output producer, output is_dummy, output packet_id,
                    input ready);
    modport sink   (input valid, input producer, input is_dummy, input packet_id,
                    output ready);
endinterface

@@ sv/sequence_aware_round_robin_scheduler.sv @@
// ----------------------------------------------------------------------------
// sequence_aware_round_robin_scheduler
// grants one producer per transmit opportunity without repeating its packet id
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one item per transmit opportunity: connected_mask and
//   wants_mask. out_ch returns exactly one item per request: the granted
//   producer, or a dummy send, plus the packet id it consumes.
// search rounds
//   one request is worked at a time. a search round is a scan pass, in which
//   the single shared pruning/bit-count unit visits each id queue in turn,
//   then a decide step (pick, grant, move an unwilling producer, or roll
//   the next queues over). the next request can be taken once the result
//   has moved to the output register; the number of rounds is capped at
//   4 * PRODUCERS + 16 (then a dummy is sent).
// reset
//   rst_n clears all queues, the next id and the handshake state; no clearing
//   pass, the block is ready to take an item as soon as reset ends.
// stalls
//   the result sits in an output register; while it waits the block already
//   takes and works the next request, and holds that second result until the
//   output register frees up.
// ----------------------------------------------------------------------------
module sequence_aware_round_robin_scheduler #(
    parameter int PRODUCERS       = sars_pkg::PRODUCERS_DEF,
    parameter int CONNECTOR_INDEX = sars_pkg::CONNECTOR_INDEX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sars_in_if.sink     in_ch,
    sars_out_if.source  out_ch
);
    import sars_pkg::*;

    // search round cap and its counter width
    localparam int ROUND_LIMIT = 4 * PRODUCERS + 16;
    localparam int RW          = $clog2(ROUND_LIMIT + 1);

    // producers at PRODUCERS and above are ignored
    localparam logic [MASK_W-1:0] PROD_MASK = {MASK_W{1'b1}} >> (MASK_W - PRODUCERS);
    // only the low 5 bits of the connector index count
    localparam logic [MASK_W-1:0] CONN_BIT  = MASK_W'(1) << (CONNECTOR_INDEX % MASK_W);
    localparam logic [ID_W-1:0]   ID_LAST   = ID_W'(ID_COUNT - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [MASK_W-1:0]     cq_reg [ID_COUNT];
    logic [MASK_W-1:0]     cq_next [ID_COUNT];
    logic [MASK_W-1:0]     nq_reg [ID_COUNT];
    logic [MASK_W-1:0]     nq_next [ID_COUNT];
    logic [ID_W-1:0]       next_id_reg, next_id_next;
    logic [MASK_W-1:0]     active_reg, active_next;
    logic [MASK_W-1:0]     willing_reg, willing_next;
    logic [ID_W-1:0]       idx_reg, idx_next;
    logic [ID_W-1:0]       best_id_reg, best_id_next;
    logic [COUNT_W-1:0]    best_cnt_reg, best_cnt_next;
    logic [RW-1:0]         round_reg, round_next;
    logic [PRODUCER_W-1:0] res_producer_reg, res_producer_next;
    logic                  res_dummy_reg, res_dummy_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PRODUCER_W-1:0] out_producer_reg, out_producer_next;
    logic                  out_dummy_reg, out_dummy_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;

    // shared unit: prune the visited queue and count its producers
    logic [MASK_W-1:0]     scan_pruned;
    logic [COUNT_W-1:0]    scan_count;
    // pick path: lowest producer of the chosen queue
    logic [PRODUCER_W-1:0] pick_idx;
    logic [MASK_W-1:0]     pick_bit;
    logic [MASK_W-1:0]     next_union;
    logic [RW-1:0]         round_inc;
    logic                  in_fire;

    assign scan_pruned = cq_reg[idx_reg] & active_reg;
    assign scan_count  = popcount32(scan_pruned);
    assign pick_idx    = lowest_index(cq_reg[best_id_reg]);
    assign pick_bit    = MASK_W'(1) << pick_idx;
    assign next_union  = nq_reg[0] | nq_reg[1] | nq_reg[2] | nq_reg[3];
    assign round_inc   = round_reg + RW'(1);

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.producer  = out_producer_reg;
    assign out_ch.is_dummy  = out_dummy_reg;
    assign out_ch.packet_id = out_id_reg;

    always_comb
    begin
        state_next        = state_reg;
        cq_next           = cq_reg;
        nq_next           = nq_reg;
        next_id_next      = next_id_reg;
        active_next       = active_reg;
        willing_next      = willing_reg;
        idx_next          = idx_reg;
        best_id_next      = best_id_reg;
        best_cnt_next     = best_cnt_reg;
        round_next        = round_reg;
        res_producer_next = res_producer_reg;
        res_dummy_next    = res_dummy_reg;
        res_id_next       = res_id_reg;
        out_valid_next    = out_valid_reg;
        out_producer_next = out_producer_reg;
        out_dummy_next    = out_dummy_reg;
        out_id_next       = out_id_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    active_next   = (in_ch.connected_mask & PROD_MASK) | CONN_BIT;
                    willing_next  = (in_ch.wants_mask & active_next) | CONN_BIT;
                    round_next    = '0;
                    idx_next      = '0;
                    best_id_next  = '0;
                    best_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // the next id queue is neither pruned nor a candidate
                if (idx_reg != next_id_reg)
                begin
                    cq_next[idx_reg] = scan_pruned;
                    if (scan_count > best_cnt_reg)
                    begin
                        best_cnt_next = scan_count;
                        best_id_next  = idx_reg;
                    end
                end
                if (idx_reg == ID_LAST)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + ID_W'(1);
                end
            end

            ST_DECIDE:
            begin
                res_id_next   = next_id_reg;
                idx_next      = '0;
                best_id_next  = '0;
                best_cnt_next = '0;
                round_next    = round_inc;
                if (best_cnt_reg == '0)
                begin
                    if (cq_reg[next_id_reg] == '0)
                    begin
                        // rollover: next queues become current, newcomers join queue 0
                        for (int i = 0; i < ID_COUNT; i++)
                        begin
                            cq_next[i] = nq_reg[i];
                            nq_next[i] = '0;
                        end
                        cq_next[0] = nq_reg[0] | (active_reg & ~next_union);
                        if (round_inc == RW'(ROUND_LIMIT))
                        begin
                            res_producer_next = '0;
                            res_dummy_next    = 1'b1;
                            next_id_next      = next_id_reg + ID_W'(1);
                            state_next        = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        // stuck on id: dummy send bumps it
                        res_producer_next = '0;
                        res_dummy_next    = 1'b1;
                        next_id_next      = next_id_reg + ID_W'(1);
                        state_next        = ST_DONE;
                    end
                end
                else
                begin
                    cq_next[best_id_reg] = cq_reg[best_id_reg] ^ pick_bit;
                    if ((willing_reg & pick_bit) != '0)
                    begin
                        nq_next[next_id_reg] = nq_reg[next_id_reg] | pick_bit;
                        res_producer_next    = pick_idx;
                        res_dummy_next       = 1'b0;
                        next_id_next         = next_id_reg + ID_W'(1);
                        state_next           = ST_DONE;
                    end
                    else
                    begin
                        // unwilling producer keeps its old id for the next pass
                        nq_next[best_id_reg] = nq_reg[best_id_reg] | pick_bit;
                        if (round_inc == RW'(ROUND_LIMIT))
                        begin
                            res_producer_next = '0;
                            res_dummy_next    = 1'b1;
                            next_id_next      = next_id_reg + ID_W'(1);
                            state_next        = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_producer_next = res_producer_reg;
                    out_dummy_next    = res_dummy_reg;
                    out_id_next       = res_id_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            best_id_reg   <= '0;
            best_cnt_reg  <= '0;
            round_reg     <= '0;
            for (int i = 0; i < ID_COUNT; i++)
            begin
                cq_reg[i] <= '0;
                nq_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            best_id_reg   <= best_id_next;
            best_cnt_reg  <= best_cnt_next;
            round_reg     <= round_next;
            cq_reg        <= cq_next;
            nq_reg        <= nq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        active_reg       <= active_next;
        willing_reg      <= willing_next;
        res_producer_reg <= res_producer_next;
        res_dummy_reg    <= res_dummy_next;
        res_id_reg       <= res_id_next;
        out_producer_reg <= out_producer_next;
        out_dummy_reg    <= out_dummy_next;
        out_id_reg       <= out_id_next;
    end

endmodule
